FILE: hw/rtl/forth_data_stack_alu_assert.svh
// ----------------------------------------------------------------------------
// forth data stack assertion macros
// clocked assertion wrappers, compiled out when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef FORTH_DATA_STACK_ALU_ASSERT_SVH
`define FORTH_DATA_STACK_ALU_ASSERT_SVH
`ifndef NO_ASSERTIONS
// checked only outside reset
`define FDSA_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("fdsa: assertion failed");
// checked at every edge, reset included
`define FDSA_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("fdsa: assertion failed");
`else
`define FDSA_ASSERT(lbl, prop)
`define FDSA_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: hw/rtl/fdsa_pkg.sv
// ----------------------------------------------------------------------------
// fdsa_pkg
// shared widths, operation and status codes, and alu request type
// ----------------------------------------------------------------------------
package fdsa_pkg;

	localparam int DATA_W      = 32;
	localparam int STACK_DEPTH = 32;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int KIND_W      = 4;
	localparam int STATUS_W    = 3;
	localparam int COUNT_W     = 6;

	// operation codes
	localparam logic [KIND_W-1:0] KIND_PUSH = 4'd0;
	localparam logic [KIND_W-1:0] KIND_POP  = 4'd1;
	localparam logic [KIND_W-1:0] KIND_TOP  = 4'd2;
	localparam logic [KIND_W-1:0] KIND_DUP  = 4'd3;
	localparam logic [KIND_W-1:0] KIND_SWAP = 4'd4;
	localparam logic [KIND_W-1:0] KIND_ADD  = 4'd5;
	localparam logic [KIND_W-1:0] KIND_SUB  = 4'd6;
	localparam logic [KIND_W-1:0] KIND_MUL  = 4'd7;
	localparam logic [KIND_W-1:0] KIND_DIV  = 4'd8;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_UNDER = 3'd1;
	localparam logic [STATUS_W-1:0] ST_SWAP  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_DIVZ  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL  = 3'd4;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL,
		ALU_DIV
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

endpackage

FILE: hw/rtl/fdsa_alu.sv
// ----------------------------------------------------------------------------
// fdsa_alu
// iterative alu around one shared 33-bit adder: add, subtract,
// shift-add multiply and restoring divide with truncation toward zero
// ----------------------------------------------------------------------------
module fdsa_alu import fdsa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  alu_req_t          req,
	input  logic [DATA_W-1:0] a,
	input  logic [DATA_W-1:0] b,
	output logic              done,
	output logic [DATA_W-1:0] result
);

	localparam int STEP_W = $clog2(DATA_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DATA_W - 1);

	typedef enum logic [2:0] {
		A_IDLE,
		A_NEGA,
		A_NEGB,
		A_ITER,
		A_FIX,
		A_DONE
	} alu_state_t;

	alu_state_t        state_q;
	alu_op_t           op_q;
	logic [DATA_W-1:0] acc_q;   // product or partial remainder
	logic [DATA_W-1:0] opd_q;   // multiplicand or divisor magnitude
	logic [DATA_W-1:0] shf_q;   // multiplier or dividend/quotient
	logic [DATA_W-1:0] res_q;
	logic [STEP_W-1:0] step_q;
	logic              neg_q;

	logic [DATA_W:0]   add_x;
	logic [DATA_W:0]   add_y;
	logic              add_ci;
	logic [DATA_W+1:0] add_s;

	// operand selection for the shared adder
	always_comb begin
		add_x  = '0;
		add_y  = '0;
		add_ci = 1'b0;
		unique case (state_q) inside
			A_IDLE: begin
				add_x = {1'b0, a};
				if (req.op == ALU_SUB) begin
					add_y  = {1'b1, ~b};
					add_ci = 1'b1;
				end else begin
					add_y = {1'b0, b};
				end
			end
			A_NEGA, A_FIX: begin
				add_y  = {1'b1, ~shf_q};
				add_ci = 1'b1;
			end
			A_NEGB: begin
				add_y  = {1'b1, ~opd_q};
				add_ci = 1'b1;
			end
			A_ITER: begin
				if (op_q == ALU_MUL) begin
					add_x = {1'b0, acc_q};
					add_y = shf_q[0] ? {1'b0, opd_q} : '0;
				end else begin
					add_x  = {acc_q, shf_q[DATA_W-1]};
					add_y  = {1'b1, ~opd_q};
					add_ci = 1'b1;
				end
			end
			default: begin
			end
		endcase
		add_s = {1'b0, add_x} + {1'b0, add_y} + (DATA_W+2)'(add_ci);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
		end else begin
			unique case (state_q)
				A_IDLE: begin
					if (req.start) begin
						op_q   <= req.op;
						acc_q  <= '0;
						opd_q  <= b;
						shf_q  <= a;
						step_q <= '0;
						neg_q  <= a[DATA_W-1] ^ b[DATA_W-1];
						unique case (req.op) inside
							ALU_ADD, ALU_SUB: begin
								res_q   <= add_s[DATA_W-1:0];
								state_q <= A_DONE;
							end
							ALU_MUL: state_q <= A_ITER;
							ALU_DIV: state_q <= A_NEGA;
							default: state_q <= A_DONE;
						endcase
					end
				end
				A_NEGA: begin
					if (shf_q[DATA_W-1])
						shf_q <= add_s[DATA_W-1:0];
					state_q <= A_NEGB;
				end
				A_NEGB: begin
					if (opd_q[DATA_W-1])
						opd_q <= add_s[DATA_W-1:0];
					state_q <= A_ITER;
				end
				A_ITER: begin
					step_q <= step_q + 1'b1;
					if (op_q == ALU_MUL) begin
						acc_q <= add_s[DATA_W-1:0];
						opd_q <= {opd_q[DATA_W-2:0], 1'b0};
						shf_q <= {1'b0, shf_q[DATA_W-1:1]};
						if (step_q == LAST_STEP) begin
							res_q   <= add_s[DATA_W-1:0];
							state_q <= A_DONE;
						end
					end else begin
						// carry out set means the divisor fits
						if (add_s[DATA_W+1]) begin
							acc_q <= add_s[DATA_W-1:0];
							shf_q <= {shf_q[DATA_W-2:0], 1'b1};
						end else begin
							acc_q <= {acc_q[DATA_W-2:0], shf_q[DATA_W-1]};
							shf_q <= {shf_q[DATA_W-2:0], 1'b0};
						end
						if (step_q == LAST_STEP)
							state_q <= A_FIX;
					end
				end
				A_FIX: begin
					res_q   <= neg_q ? add_s[DATA_W-1:0] : shf_q;
					state_q <= A_DONE;
				end
				A_DONE: state_q <= A_IDLE;
				default: state_q <= A_IDLE;
			endcase
		end
	end

	assign done   = (state_q == A_DONE);
	assign result = res_q;

endmodule

FILE: hw/rtl/forth_data_stack_alu.sv
// ----------------------------------------------------------------------------
// forth_data_stack_alu
// 32-bit signed data stack with push, pop, top, dup, swap and an
// iterative add, subtract, multiply and divide unit
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------
//  cmd      | cmd_valid/cmd_stall  | kind, push_value
//  rsp      | rsp_valid/rsp_stall  | read_value, status, stack_count
//
// push, unused codes and errors seen at accept need no store read; pop/top/dup,
// a zero divisor and a lone operand read once; swap and add/subtract read twice;
// multiply and divide run on the shared adder, one bit per cycle over 32 steps
// (divide adds a negate step for each operand and a sign fix)
// the store has one write and one registered read port, so stack reads are
// made one at a time, each in a state of its own
// reset (arst_n low) empties the stack at once; store contents are kept
// a stalled rsp does not block the next cmd at once: a finished result waits
// in a holding register until the output register is free, cmd stalls meanwhile
//
`include "forth_data_stack_alu_assert.svh"

module forth_data_stack_alu import fdsa_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	output logic                       cmd_stall,
	input  logic        [KIND_W-1:0]   kind,
	input  logic signed [DATA_W-1:0]   push_value,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output logic signed [DATA_W-1:0]   read_value,
	output logic        [STATUS_W-1:0] status,
	output logic        [COUNT_W-1:0]  stack_count
);

	typedef enum logic [2:0] {
		S_IDLE,   // waiting for a cmd transaction
		S_RD1,    // top of stack arrives from the store
		S_RD2,    // second element arrives from the store
		S_SWAP2,  // second half of the swap write-back
		S_ALU,    // waiting on the iterative unit
		S_DONE    // result ready for the output register
	} state_t;

	state_t              state_q;
	logic [KIND_W-1:0]   kind_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [DATA_W-1:0]   top_q;      // top operand kept for swap and the alu
	logic [DATA_W-1:0]   rv_q;       // result holding registers
	logic [STATUS_W-1:0] st_q;
	logic                rsp_valid_q;
	logic [DATA_W-1:0]   read_value_q;
	logic [STATUS_W-1:0] status_q;
	logic [COUNT_W-1:0]  stack_count_q;

	// stack store
	logic [DATA_W-1:0]   mem [STACK_DEPTH];
	logic [DATA_W-1:0]   mem_rd_q;
	logic [ADDR_W-1:0]   mem_raddr;
	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	logic [DATA_W-1:0]   mem_wdata;

	logic                cmd_acc;
	logic                rsp_free;
	logic                full;
	logic                empty;
	logic                below_two;
	logic                kind_q_binop;
	logic [ADDR_W-1:0]   addr_top;
	logic [ADDR_W-1:0]   addr_nos;
	logic [ADDR_W-1:0]   addr_new;

	alu_req_t            alu_req;
	logic                alu_done;
	logic [DATA_W-1:0]   alu_result;

	// handshake
	assign cmd_stall = (state_q != S_IDLE);
	assign cmd_acc   = cmd_valid && !cmd_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	// occupancy and store addresses
	assign full      = (cnt_q == CNT_W'(STACK_DEPTH));
	assign empty     = (cnt_q == '0);
	assign below_two = (cnt_q < CNT_W'(2));
	assign addr_top  = ADDR_W'(cnt_q - CNT_W'(1));
	assign addr_nos  = ADDR_W'(cnt_q - CNT_W'(2));
	assign addr_new  = ADDR_W'(cnt_q);

	assign kind_q_binop = (kind_q >= KIND_ADD) && (kind_q <= KIND_DIV);

	// store read address: top first, then the element below it
	always_comb begin
		mem_raddr = addr_top;
		if (state_q == S_RD1)
			mem_raddr = addr_nos;
	end

	// store write port
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_new;
		mem_wdata = push_value;
		unique case (state_q)
			S_IDLE: begin
				mem_we = cmd_acc && (kind == KIND_PUSH) && !full;
			end
			S_RD1: begin
				// dup copies the top into the next free slot
				mem_we    = (kind_q == KIND_DUP);
				mem_wdata = mem_rd_q;
			end
			S_RD2: begin
				// swap: old second element goes on top
				mem_we    = (kind_q == KIND_SWAP);
				mem_waddr = addr_top;
				mem_wdata = mem_rd_q;
			end
			S_SWAP2: begin
				mem_we    = 1'b1;
				mem_waddr = addr_nos;
				mem_wdata = top_q;
			end
			S_ALU: begin
				// result replaces the left operand
				mem_we    = alu_done;
				mem_waddr = addr_nos;
				mem_wdata = alu_result;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		mem_rd_q <= mem[mem_raddr];
	end

	// alu request: left operand is second from top, right is the top
	always_comb begin
		alu_req.start = (state_q == S_RD2) && kind_q_binop;
		case (kind_q)
			KIND_SUB: alu_req.op = ALU_SUB;
			KIND_MUL: alu_req.op = ALU_MUL;
			KIND_DIV: alu_req.op = ALU_DIV;
			default:  alu_req.op = ALU_ADD;
		endcase
	end

	fdsa_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (mem_rd_q),
		.b      (top_q),
		.done   (alu_done),
		.result (alu_result)
	);

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// output register empties when taken, unless a new result loads it
			if (rsp_valid_q && !rsp_stall && (state_q != S_DONE))
				rsp_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (cmd_acc) begin
						kind_q <= kind;
						rv_q   <= '0;
						st_q   <= ST_OK;
						unique case (kind) inside
							KIND_PUSH: begin
								if (full)
									st_q <= ST_FULL;
								else
									cnt_q <= cnt_q + 1'b1;
								state_q <= S_DONE;
							end
							KIND_POP, KIND_TOP: begin
								if (empty) begin
									st_q    <= ST_UNDER;
									state_q <= S_DONE;
								end else begin
									state_q <= S_RD1;
								end
							end
							KIND_DUP: begin
								if (empty) begin
									st_q    <= ST_UNDER;
									state_q <= S_DONE;
								end else if (full) begin
									st_q    <= ST_FULL;
									state_q <= S_DONE;
								end else begin
									state_q <= S_RD1;
								end
							end
							KIND_SWAP: begin
								if (below_two) begin
									st_q    <= ST_SWAP;
									state_q <= S_DONE;
								end else begin
									state_q <= S_RD1;
								end
							end
							[KIND_ADD:KIND_DIV]: begin
								// nothing popped on an empty stack
								if (empty) begin
									st_q    <= ST_UNDER;
									state_q <= S_DONE;
								end else begin
									state_q <= S_RD1;
								end
							end
							default: state_q <= S_DONE;  // unused codes do nothing
						endcase
					end
				end
				S_RD1: begin
					top_q <= mem_rd_q;
					unique case (kind_q) inside
						KIND_POP: begin
							rv_q    <= mem_rd_q;
							cnt_q   <= cnt_q - 1'b1;
							state_q <= S_DONE;
						end
						KIND_TOP: begin
							rv_q    <= mem_rd_q;
							state_q <= S_DONE;
						end
						KIND_DUP: begin
							cnt_q   <= cnt_q + 1'b1;
							state_q <= S_DONE;
						end
						KIND_SWAP: state_q <= S_RD2;
						[KIND_ADD:KIND_DIV]: begin
							if ((kind_q == KIND_DIV) && (mem_rd_q == '0)) begin
								// zero divisor is dropped, dividend stays
								st_q    <= ST_DIVZ;
								cnt_q   <= cnt_q - 1'b1;
								state_q <= S_DONE;
							end else if (cnt_q == CNT_W'(1)) begin
								// lone operand already popped
								st_q    <= ST_UNDER;
								cnt_q   <= '0;
								state_q <= S_DONE;
							end else begin
								state_q <= S_RD2;
							end
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_RD2: begin
					if (kind_q == KIND_SWAP)
						state_q <= S_SWAP2;
					else
						state_q <= S_ALU;
				end
				S_SWAP2: state_q <= S_DONE;
				S_ALU: begin
					if (alu_done) begin
						cnt_q   <= cnt_q - 1'b1;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (rsp_free) begin
						rsp_valid_q   <= 1'b1;
						read_value_q  <= rv_q;
						status_q      <= st_q;
						stack_count_q <= COUNT_W'(cnt_q);
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign read_value  = read_value_q;
	assign status      = status_q;
	assign stack_count = stack_count_q;

	// occupancy never passes the store depth once out of reset
	`FDSA_ASSERT_ALWAYS(a_cnt_bound, !arst_n || (cnt_q <= CNT_W'(STACK_DEPTH)))
	// one operation moves the count by at most one element
	`FDSA_ASSERT(a_cnt_step, CNT_W'($past(cnt_q) - cnt_q + 1'b1) <= CNT_W'(2))
	// a cmd transaction closes the input until its result is handed on
	`FDSA_ASSERT(a_single_op, (cmd_valid && !cmd_stall) |=> cmd_stall)
	// the alu only finishes while the sequencer waits for it
	`FDSA_ASSERT(a_alu_owned, alu_done |-> (state_q == S_ALU))

endmodule
